// File: rtl/jomc_pkg.sv
// ----------------------------------------------------------------------------
// jomc_pkg
// Shared types and constants for the JSON object member counter.
// ----------------------------------------------------------------------------
package jomc_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int DEPTH_WIDTH = 16;
  localparam int BYTE_WIDTH  = 8;
  localparam int MEMBER_WIDTH = 16;

  localparam logic [BYTE_WIDTH-1:0] CH_LBRACE    = 8'h7B;
  localparam logic [BYTE_WIDTH-1:0] CH_RBRACE    = 8'h7D;
  localparam logic [BYTE_WIDTH-1:0] CH_LBRACKET  = 8'h5B;
  localparam logic [BYTE_WIDTH-1:0] CH_RBRACKET  = 8'h5D;
  localparam logic [BYTE_WIDTH-1:0] CH_COMMA     = 8'h2C;
  localparam logic [BYTE_WIDTH-1:0] CH_COLON     = 8'h3A;
  localparam logic [BYTE_WIDTH-1:0] CH_DQUOTE    = 8'h22;
  localparam logic [BYTE_WIDTH-1:0] CH_SQUOTE    = 8'h27;
  localparam logic [BYTE_WIDTH-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [BYTE_WIDTH-1:0] CH_SPACE     = 8'h20;
  localparam logic [BYTE_WIDTH-1:0] CH_TAB       = 8'h09;
  localparam logic [BYTE_WIDTH-1:0] CH_CR        = 8'h0D;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SKIP = 2'd1,
    PH_SCAN = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2
  } status_t;

  typedef struct packed {
    logic [MEMBER_WIDTH-1:0] member_count;
    status_t                 status;
  } result_t;

endpackage

// File: rtl/jomc_if.sv
// ----------------------------------------------------------------------------
// jomc_in_if / jomc_out_if
// Valid/ready channels for text bytes and for count results.
// ----------------------------------------------------------------------------
interface jomc_in_if;
  logic                              valid;
  logic                              ready;
  logic [jomc_pkg::BYTE_WIDTH-1:0]   text_byte;
  logic                              first;
  logic                              last;

  modport source (output valid, output text_byte, output first, output last, input ready);
  modport sink   (input valid, input text_byte, input first, input last, output ready);
endinterface

interface jomc_out_if;
  logic                              valid;
  logic                              ready;
  logic [jomc_pkg::MEMBER_WIDTH-1:0] member_count;
  logic [1:0]                        status;

  modport source (output valid, output member_count, output status, input ready);
  modport sink   (input valid, input member_count, input status, output ready);
endinterface

// File: rtl/jomc_scan.sv
// ----------------------------------------------------------------------------
// jomc_scan
// Scan state and per-byte update; flags a result on the byte that ends a scan.
// ----------------------------------------------------------------------------
module jomc_scan (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  input  logic [jomc_pkg::BYTE_WIDTH-1:0]      text_byte,
  input  logic                                 first,
  input  logic                                 last,
  output logic                                 res_fire,
  output jomc_pkg::result_t                    res
);
  import jomc_pkg::*;

  phase_t                 phase, phase_next;
  logic                   opener_is_brace, opener_is_brace_next;
  logic [DEPTH_WIDTH-1:0] brace_depth, brace_depth_next;
  logic [DEPTH_WIDTH-1:0] bracket_depth, bracket_depth_next;
  logic                   in_double_quote, in_double_quote_next;
  logic                   in_single_quote, in_single_quote_next;
  logic [BYTE_WIDTH-1:0]  previous_byte, previous_byte_next;
  logic [COUNT_WIDTH-1:0] comma_total, comma_total_next;
  logic [COUNT_WIDTH-1:0] colon_total, colon_total_next;

  logic                   is_space;
  logic                   scan_en;
  logic                   counts;
  logic [COUNT_WIDTH:0]   member_sum;
  logic [32:0]            member_ext;

  assign is_space = (text_byte == CH_SPACE) ||
                    ((text_byte >= CH_TAB) && (text_byte <= CH_CR));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      opener_is_brace <= 1'b0;
      brace_depth     <= '0;
      bracket_depth   <= '0;
      in_double_quote <= 1'b0;
      in_single_quote <= 1'b0;
      previous_byte   <= '0;
      comma_total     <= '0;
      colon_total     <= '0;
    end else begin
      phase           <= phase_next;
      opener_is_brace <= opener_is_brace_next;
      brace_depth     <= brace_depth_next;
      bracket_depth   <= bracket_depth_next;
      in_double_quote <= in_double_quote_next;
      in_single_quote <= in_single_quote_next;
      previous_byte   <= previous_byte_next;
      comma_total     <= comma_total_next;
      colon_total     <= colon_total_next;
    end
  end

  always_comb begin
    phase_next           = phase;
    opener_is_brace_next = opener_is_brace;
    brace_depth_next     = brace_depth;
    bracket_depth_next   = bracket_depth;
    in_double_quote_next = in_double_quote;
    in_single_quote_next = in_single_quote;
    previous_byte_next   = previous_byte;
    comma_total_next     = comma_total;
    colon_total_next     = colon_total;
    res_fire             = 1'b0;
    res.member_count     = '0;
    res.status           = ST_BAD;
    scan_en              = 1'b0;
    counts               = 1'b0;
    member_sum           = '0;
    member_ext           = '0;

    if (accept) begin
      if (first) begin
        opener_is_brace_next = (text_byte == CH_LBRACE);
        brace_depth_next     = (text_byte == CH_LBRACE) ? DEPTH_WIDTH'(1) : '0;
        bracket_depth_next   = '0;
        in_double_quote_next = 1'b0;
        in_single_quote_next = 1'b0;
        previous_byte_next   = text_byte;
        comma_total_next     = '0;
        colon_total_next     = '0;
        phase_next           = PH_SKIP;
        if (last) begin
          res_fire   = 1'b1;
          res.status = ST_BAD;
          phase_next = PH_IDLE;
        end
      end else begin
        unique case (phase)
          PH_IDLE: begin
          end
          PH_SKIP: begin
            if (is_space) begin
              previous_byte_next = text_byte;
              if (last) begin
                res_fire   = 1'b1;
                res.status = ST_BAD;
                phase_next = PH_IDLE;
              end
            end else if (text_byte == CH_RBRACE) begin
              res_fire   = 1'b1;
              res.status = ST_EMPTY;
              phase_next = PH_IDLE;
            end else if (!opener_is_brace) begin
              res_fire   = 1'b1;
              res.status = ST_BAD;
              phase_next = PH_IDLE;
            end else begin
              scan_en = 1'b1;
            end
          end
          PH_SCAN: begin
            scan_en = 1'b1;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase

        if (scan_en) begin
          phase_next = PH_SCAN;
          counts = (brace_depth == DEPTH_WIDTH'(1)) && (bracket_depth == '0) &&
                   !in_double_quote && !in_single_quote;
          if (counts && (text_byte == CH_COMMA) && (comma_total != '1)) begin
            comma_total_next = comma_total + COUNT_WIDTH'(1);
          end
          if (counts && (text_byte == CH_COLON) && (colon_total != '1)) begin
            colon_total_next = colon_total + COUNT_WIDTH'(1);
          end
          if (text_byte == CH_LBRACE) begin
            if (brace_depth != '1) begin
              brace_depth_next = brace_depth + DEPTH_WIDTH'(1);
            end
          end else if ((text_byte == CH_RBRACE) && (brace_depth != '0)) begin
            brace_depth_next = brace_depth - DEPTH_WIDTH'(1);
          end
          if (text_byte == CH_LBRACKET) begin
            bracket_depth_next = bracket_depth + DEPTH_WIDTH'(1);
          end else if (text_byte == CH_RBRACKET) begin
            bracket_depth_next = bracket_depth - DEPTH_WIDTH'(1);
          end
          if ((text_byte == CH_DQUOTE) && (previous_byte != CH_BACKSLASH)) begin
            in_double_quote_next = !in_double_quote;
          end
          if ((text_byte == CH_SQUOTE) && (previous_byte != CH_BACKSLASH)) begin
            in_single_quote_next = !in_single_quote;
          end
          previous_byte_next = text_byte;

          if ((brace_depth_next == '0) || last) begin
            res_fire   = 1'b1;
            phase_next = PH_IDLE;
            member_sum = {1'b0, comma_total_next} + (COUNT_WIDTH+1)'(1);
            member_ext = 33'(member_sum);
            if (member_sum == {1'b0, colon_total_next}) begin
              res.status       = ST_OK;
              res.member_count = (member_ext > 33'h0FFFF) ? '1 :
                                 member_ext[MEMBER_WIDTH-1:0];
            end else begin
              res.status = ST_BAD;
            end
          end
        end
      end
    end
  end

endmodule

// File: rtl/json_object_member_counter_top.sv
// ----------------------------------------------------------------------------
// json_object_member_counter_top
// Pre-scan of one JSON object, counting its top-level members.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle. The byte flagged first opens a scan; the
// result (member count and status) appears in the output register in the cycle
// after the byte that closes the object or ends the text. A new byte enters
// while the output register is empty or its result is being taken; input
// stalls only while that register is full and not being drained.
module json_object_member_counter_top (
  input  logic       clk,
  input  logic       rst,
  jomc_in_if.sink    in_ch,
  jomc_out_if.source out_ch
);
  import jomc_pkg::*;

  logic    accept;
  logic    res_fire;
  result_t res;
  logic    out_valid;
  result_t out_res;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  jomc_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .text_byte (in_ch.text_byte),
    .first     (in_ch.first),
    .last      (in_ch.last),
    .res_fire  (res_fire),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && res_fire) begin
      out_res <= res;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.member_count = out_res.member_count;
  assign out_ch.status       = out_res.status;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the JSON object member counter.
// ----------------------------------------------------------------------------
// Streams text bytes into the counter and mirrors its scan one byte at a time:
// whitespace skip, brace and bracket depth, quote toggles with backslash
// escape, and comma and colon totals at the top level. Every count/status
// transaction is checked against the oldest predicted one. Directed cases
// cover the special cases. Random JSON-like objects then run with random
// gaps and stalls on both channels, with random bytes and malformed texts.
// ----------------------------------------------------------------------------
module tb;
  import jomc_pkg::*;

  logic clk;
  logic rst;

  jomc_in_if  in_ch();
  jomc_out_if out_ch();

  json_object_member_counter_top uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  phase_t                 scan_phase;
  logic                   opener_brace;
  logic [DEPTH_WIDTH-1:0] brace_lvl;
  logic [DEPTH_WIDTH-1:0] bracket_lvl;
  logic                   in_dq;
  logic                   in_sq;
  logic [BYTE_WIDTH-1:0]  prev_byte;
  logic [COUNT_WIDTH-1:0] comma_cnt;
  logic [COUNT_WIDTH-1:0] colon_cnt;

  result_t               expected_counts[$];
  logic [BYTE_WIDTH-1:0] text_buf[$];
  int                    mismatch_total;
  int                    scanned_bytes;
  bit                    send_idle_on;
  bit                    take_idle_on;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int draw_wait(bit idle_on);
    return idle_on ? $urandom_range(0, 12) : 0;
  endfunction

  function automatic void note_failure(string msg);
    mismatch_total++;
    if (mismatch_total <= 10) $display("MISMATCH: %s", msg);
  endfunction

  // Advance the scan mirror by one byte; returns 1 when a result is due.
  function automatic bit scan_byte(input logic [BYTE_WIDTH-1:0] b, input bit is_first,
                                   input bit is_last, output result_t res);
    bit counts;
    res.member_count = '0;
    res.status       = ST_BAD;
    if (is_first) begin
      opener_brace = (b == CH_LBRACE);
      brace_lvl    = opener_brace ? DEPTH_WIDTH'(1) : '0;
      bracket_lvl  = '0;
      in_dq        = 1'b0;
      in_sq        = 1'b0;
      prev_byte    = b;
      comma_cnt    = '0;
      colon_cnt    = '0;
      scan_phase   = is_last ? PH_IDLE : PH_SKIP;
      return is_last;
    end
    if (scan_phase == PH_IDLE) return 1'b0;
    if (scan_phase == PH_SKIP) begin
      if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
        prev_byte = b;
        if (is_last) scan_phase = PH_IDLE;
        return is_last;
      end
      if (b == CH_RBRACE) begin
        res.status = ST_EMPTY;
        scan_phase = PH_IDLE;
        return 1'b1;
      end
      if (!opener_brace) begin
        scan_phase = PH_IDLE;
        return 1'b1;
      end
      scan_phase = PH_SCAN;
    end
    counts = (brace_lvl == DEPTH_WIDTH'(1)) && (bracket_lvl == '0) && !in_dq && !in_sq;
    if (counts && b == CH_COMMA && comma_cnt != '1) comma_cnt++;
    if (counts && b == CH_COLON && colon_cnt != '1) colon_cnt++;
    if (b == CH_LBRACE) begin
      if (brace_lvl != '1) brace_lvl++;
    end else if (b == CH_RBRACE && brace_lvl != '0) begin
      brace_lvl--;
    end
    if (b == CH_LBRACKET) bracket_lvl++;
    else if (b == CH_RBRACKET) bracket_lvl--;
    if (b == CH_DQUOTE && prev_byte != CH_BACKSLASH) in_dq = !in_dq;
    if (b == CH_SQUOTE && prev_byte != CH_BACKSLASH) in_sq = !in_sq;
    prev_byte = b;
    if (brace_lvl == '0 || is_last) begin
      scan_phase = PH_IDLE;
      if ({1'b0, comma_cnt} + 1'b1 == {1'b0, colon_cnt}) begin
        res.member_count = MEMBER_WIDTH'(comma_cnt + 1'b1);
        res.status       = ST_OK;
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_byte(input logic [BYTE_WIDTH-1:0] b, input bit is_first,
                           input bit is_last);
    int      gap;
    result_t res;
    gap = draw_wait(send_idle_on);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.text_byte <= b;
    in_ch.first     <= is_first;
    in_ch.last      <= is_last;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    if (is_first || scan_phase != PH_IDLE) scanned_bytes++;
    if (scan_byte(b, is_first, is_last, res)) expected_counts.push_back(res);
  endtask

  task automatic send_text(string s, bit end_last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], i == 0, end_last && i == s.len() - 1);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_counts.size() != 0) @(posedge clk);
  endtask

  function automatic void put_space();
    repeat ($urandom_range(0, 2))
      text_buf.push_back($urandom_range(0, 5) == 5 ? CH_SPACE :
                         BYTE_WIDTH'(CH_TAB + $urandom_range(0, 4)));
  endfunction

  function automatic void put_string();
    logic [BYTE_WIDTH-1:0] quote;
    quote = ($urandom_range(0, 4) == 0) ? CH_SQUOTE : CH_DQUOTE;
    text_buf.push_back(quote);
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 9))
        0: begin
          text_buf.push_back(CH_BACKSLASH);
          text_buf.push_back(quote);
        end
        1: text_buf.push_back(BYTE_WIDTH'($urandom_range(32, 126)));
        default: text_buf.push_back(BYTE_WIDTH'("a" + $urandom_range(0, 25)));
      endcase
    end
    text_buf.push_back(quote);
  endfunction

  function automatic void put_value(int lvl);
    int n;
    case ($urandom_range(0, lvl < 3 ? 3 : 1))
      0: repeat ($urandom_range(1, 3)) text_buf.push_back(BYTE_WIDTH'("0" + $urandom_range(0, 9)));
      1: put_string();
      2: begin
        text_buf.push_back(CH_LBRACKET);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) text_buf.push_back(CH_COMMA);
          put_value(lvl + 1);
        end
        text_buf.push_back(CH_RBRACKET);
      end
      default: put_object(lvl + 1);
    endcase
  endfunction

  function automatic void put_object(int lvl);
    int n;
    n = $urandom_range(0, lvl == 0 ? 5 : 2);
    text_buf.push_back(CH_LBRACE);
    put_space();
    for (int i = 0; i < n; i++) begin
      if (i > 0 || $urandom_range(0, 29) == 0) text_buf.push_back(CH_COMMA);
      put_space();
      put_string();
      put_space();
      if ($urandom_range(0, 29) != 0) text_buf.push_back(CH_COLON);
      put_space();
      put_value(lvl);
      put_space();
    end
    text_buf.push_back(CH_RBRACE);
  endfunction

  task automatic test_edge_cases();
    send_idle_on = 1'b1;
    take_idle_on = 1'b1;
    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_text("[\t}", 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_text("{ ", 1'b1);
    send_text("{\"\\\"\":[,],'x':{}}", 1'b0);
    send_text("{\"}", 1'b0);
    send_text("{a:", 1'b0);
    send_text("{}", 1'b0);
    send_text("{a:1", 1'b1);
    send_text("{]:}", 1'b0);
  endtask

  task automatic test_random_objects();
    int target;
    int records;
    int pick;
    int stop;
    bit with_end;
    target  = scanned_bytes + 2000;
    records = 0;
    while (scanned_bytes < target) begin
      if (records % 25 == 0) begin
        send_idle_on = $urandom_range(0, 2) != 0;
        take_idle_on = $urandom_range(0, 2) != 0;
      end
      if (records == 40) wait_for_results();
      records++;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 8))
          send_byte(BYTE_WIDTH'($urandom), $urandom_range(0, 3) == 0,
                    $urandom_range(0, 7) == 0);
      end else begin
        text_buf.delete();
        if (pick < 20) begin
          text_buf.push_back(pick < 14 ? BYTE_WIDTH'($urandom) : CH_LBRACKET);
          put_space();
          text_buf.push_back($urandom_range(0, 1) ? CH_RBRACE : BYTE_WIDTH'($urandom));
        end else begin
          put_object(0);
        end
        stop     = text_buf.size() - 1;
        with_end = $urandom_range(0, 99) < 85;
        if ($urandom_range(0, 6) == 0) stop = $urandom_range(0, stop);
        for (int i = 0; i <= stop; i++)
          send_byte(text_buf[i], i == 0, with_end && i == stop);
      end
    end
  endtask

  always @(posedge clk) begin : count_checker
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_counts.size() == 0) begin
        note_failure($sformatf("unexpected result count=%0d status=%0d",
                               out_ch.member_count, out_ch.status));
      end else begin
        want = expected_counts.pop_front();
        if (out_ch.member_count !== want.member_count || out_ch.status !== want.status)
          note_failure($sformatf("expected count=%0d status=%0d, got count=%0d status=%0d",
                                 want.member_count, want.status,
                                 out_ch.member_count, out_ch.status));
      end
    end
  end

  initial begin : result_taker
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_wait(take_idle_on);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.text_byte <= '0;
    in_ch.first     <= 1'b0;
    in_ch.last      <= 1'b0;
    scan_phase      = PH_IDLE;
    opener_brace    = 1'b0;
    brace_lvl       = '0;
    bracket_lvl     = '0;
    in_dq           = 1'b0;
    in_sq           = 1'b0;
    prev_byte       = '0;
    comma_cnt       = '0;
    colon_cnt       = '0;
    mismatch_total  = 0;
    scanned_bytes   = 0;
    send_idle_on    = 1'b0;
    take_idle_on    = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_edge_cases();
    test_random_objects();
    wait_for_results();
    repeat (20) @(posedge clk);
    while (expected_counts.size() != 0) begin
      void'(expected_counts.pop_front());
      note_failure("expected result never arrived");
    end
    if (mismatch_total == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/jomc_pkg.sv
rtl/jomc_if.sv
rtl/jomc_scan.sv
rtl/json_object_member_counter_top.sv
sim/tb.sv
